// ===== rtl/cqr_pkg.sv =====
// ----------------------------------------------------------------------------
// cqr_pkg
// shared codes and constants of the circle quadrant rasterizer
// ----------------------------------------------------------------------------
`default_nettype none

package cqr_pkg;

    // default coordinate width
    localparam int COORD_BITS_DEF = 11;

    // reset value of both scene size registers
    localparam int SCENE_RESET = 2048;

    // configuration register index
    localparam int CFG_INDEX_BITS = 1;

    typedef enum logic [CFG_INDEX_BITS-1:0] {
        REG_SCENE_WIDTH  = 1'b0,
        REG_SCENE_HEIGHT = 1'b1
    } cfg_reg_t;

    // request kinds carried in tuser
    typedef enum logic {
        REQ_START = 1'b0,
        REQ_STEP  = 1'b1
    } req_type_t;

    // part flag bit positions
    localparam int PF_BITS  = 7;
    localparam int PF_Q1    = 0;
    localparam int PF_Q2    = 1;
    localparam int PF_Q3    = 2;
    localparam int PF_Q4    = 3;
    localparam int PF_HALF1 = 4;
    localparam int PF_HALF2 = 5;
    localparam int PF_FULL  = 6;

    localparam int NUM_POINTS = 4;

endpackage

`default_nettype wire

// ===== rtl/cqr_step.sv =====
// ----------------------------------------------------------------------------
// cqr_step
// one circle iteration: start load, radius clamp, mirrored points, advance
// ----------------------------------------------------------------------------
`default_nettype none

module cqr_step #(
    parameter int COORD_BITS = cqr_pkg::COORD_BITS_DEF,
    localparam int XW = COORD_BITS + 1,
    localparam int DW = COORD_BITS + 5,
    localparam int PW = COORD_BITS + 2
) (
    input  logic                          start,
    input  logic [COORD_BITS-1:0]         center_x,
    input  logic [COORD_BITS-1:0]         center_y,
    input  logic [COORD_BITS-1:0]         radius,
    input  logic [cqr_pkg::PF_BITS-1:0]   part_flags,
    input  logic [XW-1:0]                 scene_width,
    input  logic [XW-1:0]                 scene_height,
    input  logic                          active,
    input  logic [XW-1:0]                 step_x,
    input  logic signed [XW-1:0]          step_y,
    input  logic signed [DW-1:0]          decision,
    input  logic [COORD_BITS-1:0]         origin_x,
    input  logic [COORD_BITS-1:0]         origin_y,
    input  logic [cqr_pkg::NUM_POINTS-1:0] quadrant_enable,
    output logic                          active_next,
    output logic [XW-1:0]                 step_x_next,
    output logic signed [XW-1:0]          step_y_next,
    output logic signed [DW-1:0]          decision_next,
    output logic [COORD_BITS-1:0]         origin_x_next,
    output logic [COORD_BITS-1:0]         origin_y_next,
    output logic [cqr_pkg::NUM_POINTS-1:0] quadrant_enable_next,
    output logic signed [PW-1:0]          pt0_x,
    output logic signed [PW-1:0]          pt0_y,
    output logic signed [PW-1:0]          pt1_x,
    output logic signed [PW-1:0]          pt1_y,
    output logic signed [PW-1:0]          pt2_x,
    output logic signed [PW-1:0]          pt2_y,
    output logic signed [PW-1:0]          pt3_x,
    output logic signed [PW-1:0]          pt3_y,
    output logic [cqr_pkg::NUM_POINTS-1:0] point_mask,
    output logic                          last
);
    import cqr_pkg::*;

    localparam int AW = COORD_BITS + 7;
    localparam logic signed [AW-1:0] ONE = 1;

    logic signed [COORD_BITS+1:0] dw_diff;
    logic signed [COORD_BITS+1:0] dh_diff;
    logic [XW-1:0]                dw_abs;
    logic [XW-1:0]                dh_abs;
    logic [COORD_BITS-1:0]        r_w;
    logic [COORD_BITS-1:0]        r_clamp;
    logic signed [DW-1:0]         init_d;
    logic [NUM_POINTS-1:0]        init_q;

    logic [XW-1:0]                cur_x;
    logic signed [XW-1:0]         cur_y;
    logic signed [DW-1:0]         cur_d;
    logic [COORD_BITS-1:0]        cur_ox;
    logic [COORD_BITS-1:0]        cur_oy;
    logic [NUM_POINTS-1:0]        cur_q;

    logic signed [AW-1:0] xa, ya, da, oxa, oya, err, x1, y1, d1;
    logic                 d_neg, d_pos, err_pos, run;

    // radius clamp against the scene edges
    always_comb
    begin
        dw_diff = $signed({2'b00, center_x}) - $signed({1'b0, scene_width});
        dh_diff = $signed({2'b00, center_y}) - $signed({1'b0, scene_height});
        dw_abs  = dw_diff[COORD_BITS+1] ? XW'(-dw_diff) : XW'(dw_diff);
        dh_abs  = dh_diff[COORD_BITS+1] ? XW'(-dh_diff) : XW'(dh_diff);
        r_w     = (dw_abs < {1'b0, radius}) ? dw_abs[COORD_BITS-1:0] : radius;
        r_clamp = (dh_abs < {1'b0, r_w}) ? dh_abs[COORD_BITS-1:0] : r_w;
        init_d  = DW'(2) - DW'({r_clamp, 1'b0});
        init_q[0] = part_flags[PF_Q1] | part_flags[PF_HALF1] | part_flags[PF_FULL];
        init_q[1] = part_flags[PF_Q2] | part_flags[PF_HALF1] | part_flags[PF_FULL];
        init_q[2] = part_flags[PF_Q3] | part_flags[PF_HALF2] | part_flags[PF_FULL];
        init_q[3] = part_flags[PF_Q4] | part_flags[PF_HALF2] | part_flags[PF_FULL];
    end

    // iteration to emit: freshly loaded on start, else the running one
    always_comb
    begin
        cur_x  = start ? '0 : step_x;
        cur_y  = start ? $signed({1'b0, r_clamp}) : step_y;
        cur_d  = start ? init_d : decision;
        cur_ox = start ? center_x : origin_x;
        cur_oy = start ? center_y : origin_y;
        cur_q  = start ? init_q : quadrant_enable;
        run    = start | active;
    end

    // three-way decision update
    always_comb
    begin
        xa  = AW'(cur_x);
        ya  = AW'(cur_y);
        da  = AW'(cur_d);
        oxa = AW'(cur_ox);
        oya = AW'(cur_oy);
        err = ((da + ya) <<< 1) - ONE;
        d_neg   = cur_d[DW-1];
        d_pos   = !cur_d[DW-1] && (cur_d != '0);
        err_pos = !err[AW-1] && (err != '0);
        priority if (d_neg && !err_pos)
        begin
            x1 = xa + ONE;
            y1 = ya;
            d1 = da + (x1 <<< 1) + ONE;
        end
        else if (d_pos && err_pos)
        begin
            x1 = xa;
            y1 = ya - ONE;
            d1 = da - (y1 <<< 1) - ONE;
        end
        else
        begin
            x1 = xa + ONE;
            y1 = ya - ONE;
            d1 = da + ((x1 - ya) <<< 1);
        end
    end

    always_comb
    begin
        if (run)
        begin
            pt0_x = PW'(oxa + xa);
            pt0_y = PW'(oya + ya);
            pt1_x = PW'(oxa + xa);
            pt1_y = PW'(oya - ya);
            pt2_x = PW'(oxa - xa);
            pt2_y = PW'(oya - ya);
            pt3_x = PW'(oxa - xa);
            pt3_y = PW'(oya + ya);
            point_mask           = cur_q;
            last                 = y1[AW-1];
            active_next          = !y1[AW-1];
            step_x_next          = XW'(x1);
            step_y_next          = XW'(y1);
            decision_next        = DW'(d1);
            origin_x_next        = cur_ox;
            origin_y_next        = cur_oy;
            quadrant_enable_next = cur_q;
        end
        else
        begin
            // step with no circle running: empty result, state held
            pt0_x = '0;
            pt0_y = '0;
            pt1_x = '0;
            pt1_y = '0;
            pt2_x = '0;
            pt2_y = '0;
            pt3_x = '0;
            pt3_y = '0;
            point_mask           = '0;
            last                 = 1'b1;
            active_next          = active;
            step_x_next          = step_x;
            step_y_next          = step_y;
            decision_next        = decision;
            origin_x_next        = origin_x;
            origin_y_next        = origin_y;
            quadrant_enable_next = quadrant_enable;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/circle_quadrant_rasterizer_core.sv =====
// ----------------------------------------------------------------------------
// circle_quadrant_rasterizer_core
// bresenham circle generator with quadrant and half selection
// ----------------------------------------------------------------------------
// path: a request transaction reaches its result transaction by way of the
//   input register and then the result register
// throughput: one request per cycle unless m_tready stalls the result; the
//   iteration update is one short add/compare path between input and result registers
// reset: rst_n clears the circle state and the valid flags, scene size
//   registers return to 2048; no clearing pass
// ----------------------------------------------------------------------------
`default_nettype none

module circle_quadrant_rasterizer_core #(
    parameter int COORD_BITS = cqr_pkg::COORD_BITS_DEF,
    localparam int XW    = COORD_BITS + 1,
    localparam int PW    = COORD_BITS + 2,
    localparam int IN_W  = ((3 * COORD_BITS + cqr_pkg::PF_BITS + 7) / 8) * 8,
    localparam int OUT_W = 8 * PW + 8
) (
    input  logic                              clk,
    input  logic                              rst_n,
    // configuration write port
    input  logic                              cfg_we,
    input  logic [cqr_pkg::CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [XW-1:0]                     cfg_wdata,
    // request stream
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [IN_W-1:0]                   s_tdata,  // center_x, center_y, radius, part_flags
    input  logic [0:0]                        s_tuser,  // req_type
    // result stream
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [OUT_W-1:0]                  m_tdata,  // pt0_x, pt0_y, pt1_x, pt1_y, pt2_x,
                                                        // pt2_y, pt3_x, pt3_y, point_mask
    output logic                              m_tlast   // last
);
    import cqr_pkg::*;

    localparam int C  = COORD_BITS;
    localparam int DW = COORD_BITS + 5;
    localparam int NP = NUM_POINTS;

    // configuration registers
    logic [XW-1:0] scene_width_reg;
    logic [XW-1:0] scene_height_reg;

    // input register stage
    logic               in_valid_reg, in_valid_next;
    logic               in_start_reg;
    logic [C-1:0]       in_cx_reg, in_cy_reg, in_r_reg;
    logic [PF_BITS-1:0] in_pf_reg;

    // circle state
    logic                 active_reg, active_next;
    logic [XW-1:0]        step_x_reg, step_x_next;
    logic signed [XW-1:0] step_y_reg, step_y_next;
    logic signed [DW-1:0] decision_reg, decision_next;
    logic [C-1:0]         origin_x_reg, origin_x_next;
    logic [C-1:0]         origin_y_reg, origin_y_next;
    logic [NP-1:0]        quad_en_reg, quad_en_next;

    // result register stage
    logic             m_tvalid_reg, m_tvalid_next;
    logic [OUT_W-1:0] m_tdata_reg, m_tdata_next;
    logic             m_tlast_reg;

    // datapath results
    logic signed [PW-1:0] pt0_x, pt0_y, pt1_x, pt1_y, pt2_x, pt2_y, pt3_x, pt3_y;
    logic [NP-1:0]        res_mask;
    logic                 res_last;

    logic s_accept;
    logic advance;

    // the result register frees up as soon as its transaction completes,
    // so the input stage moves on in the same cycle
    assign advance  = in_valid_reg && (!m_tvalid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;
    assign s_accept = s_tvalid && s_tready;

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tlast  = m_tlast_reg;

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scene_width_reg  <= XW'(SCENE_RESET);
            scene_height_reg <= XW'(SCENE_RESET);
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_SCENE_WIDTH:  scene_width_reg  <= cfg_wdata;
                REG_SCENE_HEIGHT: scene_height_reg <= cfg_wdata;
                default:          scene_width_reg  <= scene_width_reg;
            endcase
        end
    end

    // input stage
    always_comb
    begin
        priority if (s_accept)
            in_valid_next = 1'b1;
        else if (advance)
            in_valid_next = 1'b0;
        else
            in_valid_next = in_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else
            in_valid_reg <= in_valid_next;
    end

    // payload needs no reset
    always_ff @(posedge clk)
    begin
        if (s_accept)
        begin
            in_start_reg <= (s_tuser[0] == REQ_START);
            in_cx_reg    <= s_tdata[C-1:0];
            in_cy_reg    <= s_tdata[2*C-1:C];
            in_r_reg     <= s_tdata[3*C-1:2*C];
            in_pf_reg    <= s_tdata[3*C+PF_BITS-1:3*C];
        end
    end

    // one iteration of the circle, fed from the input stage and the state
    cqr_step #(
        .COORD_BITS (COORD_BITS)
    ) u_step (
        .start                (in_start_reg),
        .center_x             (in_cx_reg),
        .center_y             (in_cy_reg),
        .radius               (in_r_reg),
        .part_flags           (in_pf_reg),
        .scene_width          (scene_width_reg),
        .scene_height         (scene_height_reg),
        .active               (active_reg),
        .step_x               (step_x_reg),
        .step_y               (step_y_reg),
        .decision             (decision_reg),
        .origin_x             (origin_x_reg),
        .origin_y             (origin_y_reg),
        .quadrant_enable      (quad_en_reg),
        .active_next          (active_next),
        .step_x_next          (step_x_next),
        .step_y_next          (step_y_next),
        .decision_next        (decision_next),
        .origin_x_next        (origin_x_next),
        .origin_y_next        (origin_y_next),
        .quadrant_enable_next (quad_en_next),
        .pt0_x                (pt0_x),
        .pt0_y                (pt0_y),
        .pt1_x                (pt1_x),
        .pt1_y                (pt1_y),
        .pt2_x                (pt2_x),
        .pt2_y                (pt2_y),
        .pt3_x                (pt3_x),
        .pt3_y                (pt3_y),
        .point_mask           (res_mask),
        .last                 (res_last)
    );

    // state moves only when the request leaves the input stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg   <= 1'b0;
            step_x_reg   <= '0;
            step_y_reg   <= '0;
            decision_reg <= '0;
            origin_x_reg <= '0;
            origin_y_reg <= '0;
            quad_en_reg  <= '0;
        end
        else if (advance)
        begin
            active_reg   <= active_next;
            step_x_reg   <= step_x_next;
            step_y_reg   <= step_y_next;
            decision_reg <= decision_next;
            origin_x_reg <= origin_x_next;
            origin_y_reg <= origin_y_next;
            quad_en_reg  <= quad_en_next;
        end
    end

    // result packing, pt0_x in the lowest bits
    always_comb
    begin
        m_tdata_next                  = '0;
        m_tdata_next[1*PW-1:0*PW]     = pt0_x;
        m_tdata_next[2*PW-1:1*PW]     = pt0_y;
        m_tdata_next[3*PW-1:2*PW]     = pt1_x;
        m_tdata_next[4*PW-1:3*PW]     = pt1_y;
        m_tdata_next[5*PW-1:4*PW]     = pt2_x;
        m_tdata_next[6*PW-1:5*PW]     = pt2_y;
        m_tdata_next[7*PW-1:6*PW]     = pt3_x;
        m_tdata_next[8*PW-1:7*PW]     = pt3_y;
        m_tdata_next[8*PW+NP-1:8*PW]  = res_mask;
    end

    always_comb
    begin
        priority if (advance)
            m_tvalid_next = 1'b1;
        else if (m_tready)
            m_tvalid_next = 1'b0;
        else
            m_tvalid_next = m_tvalid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_tvalid_reg <= 1'b0;
        else
            m_tvalid_reg <= m_tvalid_next;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            m_tdata_reg <= m_tdata_next;
            m_tlast_reg <= res_last;
        end
    end

    // a circle ends only with a result that carries last
    a_end_with_last: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(active_reg) |-> $past(advance && res_last))
        else $error("circle dropped without a last result");

    // a last result always leaves the generator idle
    a_last_goes_idle: assert property (@(posedge clk) disable iff (!rst_n)
        advance && res_last |=> !active_reg)
        else $error("generator still active after last result");

    // a processed request always shows up as a result
    a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> m_tvalid)
        else $error("processed request produced no result");

endmodule

`default_nettype wire
